@@ hdl/swfc_pkg.sv @@
// Package for the sync-word frame checker: frame geometry, sync constants,
// and the command/status structs between the controller and the datapath.
// Depends on nothing; every other file of the block imports it.
package swfc_pkg;

   // Frame geometry. The frame length counts the sync pair and the checksum.
   localparam int FRAME_LEN = 16;
   localparam int ADDR_W    = $clog2(FRAME_LEN);
   localparam int PAY_COUNT = FRAME_LEN - 4;

   // Fixed field widths.
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;
   localparam int SUM_W  = 16;

   // Sync pair.
   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hAA;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h55;

   // Result status codes.
   localparam logic STATUS_GOOD     = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic byte_acc;   // An input transaction is taken this cycle.
      logic rd_en;      // Read the next payload byte from the frame store.
      logic load_pay;   // Load a payload result into the output register.
      logic load_fail;  // Load a mismatch result into the output register.
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic frame_done; // The byte on the input completes a frame.
      logic sum_match;  // The checksum of that frame matches.
      logic idx_last;   // The payload index points at the final payload byte.
      logic out_free;   // The output register can take a result this cycle.
   } dp_status_type;

endpackage

@@ hdl/sync_word_frame_checker_top.sv @@
// Top level of the sync-word frame checker: joins the controller and the
// datapath. Depends on swfc_pkg, swfc_ctrl and swfc_dp.
//
//   Channel | Ports                         | Direction | Carries
//   req     | req_valid/req_stall           | in        | one received byte
//   rsp     | rsp_valid/rsp_stall           | out       | one payload or mismatch result
//
// A byte that does not complete a frame is taken whenever it is offered.
// After the final byte of a good frame, each payload byte is read from the
// frame store and then loaded into the output register; after a bad frame,
// a single mismatch result is loaded into the output register.
// Input is stalled while results are emitted.
// Reset is synchronous; the frame store needs no clearing pass.
// A stalled output holds its result and the emission waits for it.
module sync_word_frame_checker_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [swfc_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [swfc_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [swfc_pkg::IDX_W-1:0]    rsp_byte_index,
   output logic                          rsp_last_of_run,
   output logic [swfc_pkg::SUM_W-1:0]    rsp_sum_received,
   output logic [swfc_pkg::SUM_W-1:0]    rsp_sum_computed
);
   import swfc_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Controller.
   swfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   swfc_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_sum_received (rsp_sum_received),
      .rsp_sum_computed (rsp_sum_computed)
   );

   // A mismatch result is a single, final result with zeroed payload fields.
   a_fail_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_MISMATCH) |->
      (rsp_last_of_run && rsp_payload_byte == '0 && rsp_byte_index == '0))
      else $error("mismatch result has a bad shape");

   // A good payload result always carries equal sums.
   a_good_sums: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_GOOD) |->
      (rsp_sum_received == rsp_sum_computed))
      else $error("good result with differing sums");

   // Once the final byte of a frame is taken, input stalls for the results.
   a_stall_after_frame: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && status.frame_done) |=> req_stall)
      else $error("input not stalled after frame completion");

endmodule

@@ hdl/swfc_ctrl.sv @@
// Controller of the sync-word frame checker: sequences byte intake and the
// emission of results. Depends on swfc_pkg for the command/status structs.
module swfc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  swfc_pkg::dp_status_type status,
   output swfc_pkg::dp_cmd_type    cmd
);
   import swfc_pkg::*;

   typedef enum logic [3:0] {
      ST_RECV = 4'b0001,
      ST_READ = 4'b0010,
      ST_LOAD = 4'b0100,
      ST_FAIL = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_RECV: begin
            req_stall    = 1'b0;
            cmd.byte_acc = req_valid;
            if (req_valid && status.frame_done) begin
               state_in = status.sum_match ? ST_READ : ST_FAIL;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_pay = 1'b1;
               state_in     = status.idx_last ? ST_RECV : ST_READ;
            end
         end
         ST_FAIL: begin
            if (status.out_free) begin
               cmd.load_fail = 1'b1;
               state_in      = ST_RECV;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/swfc_dp.sv @@
// Datapath of the sync-word frame checker: fill count, running sum, frame
// store, payload index and the output register. Depends on swfc_pkg.
module swfc_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [swfc_pkg::BYTE_W-1:0]   req_rx_byte,
   input  swfc_pkg::dp_cmd_type          cmd,
   output swfc_pkg::dp_status_type       status,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic                          rsp_status,
   output logic [swfc_pkg::BYTE_W-1:0]   rsp_payload_byte,
   output logic [swfc_pkg::IDX_W-1:0]    rsp_byte_index,
   output logic                          rsp_last_of_run,
   output logic [swfc_pkg::SUM_W-1:0]    rsp_sum_received,
   output logic [swfc_pkg::SUM_W-1:0]    rsp_sum_computed
);
   import swfc_pkg::*;

   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0] srx_lo_ff;
   logic [SUM_W-1:0]  srx_ff, scmp_ff;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [BYTE_W-1:0] frame_mem [FRAME_LEN];
   logic [SUM_W-1:0]  srx_now;
   logic [ADDR_W-1:0] rd_addr;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              is_final;
   logic              rsp_status_ff;
   logic [BYTE_W-1:0] rsp_payload_byte_ff;
   logic [IDX_W-1:0]  rsp_byte_index_ff;
   logic              rsp_last_of_run_ff;
   logic [SUM_W-1:0]  rsp_sum_received_ff;
   logic [SUM_W-1:0]  rsp_sum_computed_ff;

   assign is_final = (pos_ff == ADDR_W'(FRAME_LEN - 1));
   assign srx_now  = {req_rx_byte, srx_lo_ff};
   assign rd_addr  = ADDR_W'(idx_ff + IDX_W'(2));

   // Status toward the controller.
   always_comb begin
      status.frame_done = is_final;
      status.sum_match  = (srx_now == sum_ff);
      status.idx_last   = (idx_ff == IDX_W'(PAY_COUNT - 1));
      status.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Sync hunt, fill count and running sum.
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (cmd.byte_acc) begin
         priority if (pos_ff == ADDR_W'(0)) begin
            if (req_rx_byte == SYNC_FIRST) begin
               pos_in = ADDR_W'(1);
               sum_in = SUM_W'(req_rx_byte);
            end
         end else if (pos_ff == ADDR_W'(1)) begin
            if (req_rx_byte == SYNC_SECOND) begin
               pos_in = ADDR_W'(2);
               sum_in = sum_ff + SUM_W'(req_rx_byte);
            end else begin
               pos_in = '0;
               sum_in = '0;
            end
         end else if (is_final) begin
            pos_in = '0;
            sum_in = '0;
         end else begin
            pos_in = pos_ff + ADDR_W'(1);
            if (pos_ff < ADDR_W'(FRAME_LEN - 2)) begin
               sum_in = sum_ff + SUM_W'(req_rx_byte);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         sum_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Checksum capture at the end of a frame.
   always_ff @(posedge clock) begin
      if (cmd.byte_acc && pos_ff == ADDR_W'(FRAME_LEN - 2)) begin
         srx_lo_ff <= req_rx_byte;
      end
      if (cmd.byte_acc && is_final) begin
         srx_ff  <= srx_now;
         scmp_ff <= sum_ff;
      end
   end

   // Frame store: written on each taken byte, read one payload byte at a time.
   always_ff @(posedge clock) begin
      if (cmd.byte_acc) begin
         frame_mem[pos_ff] <= req_rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   // Payload index: cleared when a frame completes, stepped per payload result.
   always_comb begin
      idx_in = idx_ff;
      if (cmd.byte_acc && is_final) begin
         idx_in = '0;
      end else if (cmd.load_pay) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   // Output register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_pay || cmd.load_fail) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.load_pay) begin
         rsp_status_ff       <= STATUS_GOOD;
         rsp_payload_byte_ff <= rd_data_ff;
         rsp_byte_index_ff   <= idx_ff;
         rsp_last_of_run_ff  <= status.idx_last;
         rsp_sum_received_ff <= srx_ff;
         rsp_sum_computed_ff <= scmp_ff;
      end else if (cmd.load_fail) begin
         rsp_status_ff       <= STATUS_MISMATCH;
         rsp_payload_byte_ff <= '0;
         rsp_byte_index_ff   <= '0;
         rsp_last_of_run_ff  <= 1'b1;
         rsp_sum_received_ff <= srx_ff;
         rsp_sum_computed_ff <= scmp_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_payload_byte = rsp_payload_byte_ff;
   assign rsp_byte_index   = rsp_byte_index_ff;
   assign rsp_last_of_run  = rsp_last_of_run_ff;
   assign rsp_sum_received = rsp_sum_received_ff;
   assign rsp_sum_computed = rsp_sum_computed_ff;

endmodule

@@ test/tb_sync_word_frame_checker_top.sv @@
`timescale 1ns / 100ps
// Testbench for sync_word_frame_checker_top: drives byte streams with sync pairs and
// checksummed frames, predicts payload and mismatch results, and checks each result.
// Depends on swfc_pkg and the RTL of the block; it needs no other file.

module tb_sync_word_frame_checker_top;
   import swfc_pkg::*;

   // One result transaction as seen on the rsp channel.
   typedef struct {
      logic                status;
      logic [BYTE_W-1:0]   payload_byte;
      logic [IDX_W-1:0]    byte_index;
      logic                last_of_run;
      logic [SUM_W-1:0]    sum_received;
      logic [SUM_W-1:0]    sum_computed;
   } frame_result_type;

   // Tracks the frame state, predicts results for accepted bytes, and checks results.
   class frame_scoreboard;
      logic [6:0]          fill_count;
      logic [BYTE_W-1:0]   frame_bytes [FRAME_LEN];
      logic [SUM_W-1:0]    running_sum;
      frame_result_type    expected_q [$];
      int                  fail_count;

      function new();
         fill_count  = '0;
         running_sum = '0;
         fail_count  = 0;
      endfunction

      // Advance the frame state by one accepted byte and queue what it causes.
      function void note_rx_byte(logic [BYTE_W-1:0] rx);
         int               pos;
         int               i;
         logic [SUM_W-1:0] word_rx;
         logic [SUM_W-1:0] word_sum;
         frame_result_type r;
         pos = fill_count;

         // Hunting for the first sync byte; anything else is noise.
         if (pos == 0) begin
            if (rx == SYNC_FIRST) begin
               frame_bytes[0] = rx;
               running_sum    = SUM_W'(rx);
               fill_count     = 7'd1;
            end
            return;
         end

         // A wrong second byte drops the hunt without being rechecked.
         if (pos == 1) begin
            if (rx == SYNC_SECOND) begin
               frame_bytes[1] = rx;
               running_sum    = running_sum + SUM_W'(rx);
               fill_count     = 7'd2;
            end else begin
               fill_count  = '0;
               running_sum = '0;
            end
            return;
         end

         // Capture the byte; the checksum bytes stay out of the sum.
         frame_bytes[pos] = rx;
         if (pos < FRAME_LEN - 2) begin
            running_sum = running_sum + SUM_W'(rx);
         end
         if (pos + 1 < FRAME_LEN) begin
            fill_count = 7'(pos + 1);
            return;
         end

         // Final frame byte: compare the carried word with the running sum.
         word_rx     = {frame_bytes[FRAME_LEN-1], frame_bytes[FRAME_LEN-2]};
         word_sum    = running_sum;
         fill_count  = '0;
         running_sum = '0;
         r.sum_received = word_rx;
         r.sum_computed = word_sum;
         if (word_rx == word_sum) begin
            for (i = 0; i < PAY_COUNT; i++) begin
               r.status       = STATUS_GOOD;
               r.payload_byte = frame_bytes[i+2];
               r.byte_index   = IDX_W'(i);
               r.last_of_run  = (i == PAY_COUNT - 1);
               expected_q.push_back(r);
            end
         end else begin
            r.status       = STATUS_MISMATCH;
            r.payload_byte = '0;
            r.byte_index   = '0;
            r.last_of_run  = 1'b1;
            expected_q.push_back(r);
         end
      endfunction

      function void compare_field(string field_name, logic [SUM_W-1:0] want,
                                  logic [SUM_W-1:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field_name, want, got);
            fail_count++;
         end
      endfunction

      // Compare one accepted result with the oldest expected one.
      function void check_result(frame_result_type got);
         frame_result_type want;
         if (expected_q.size() == 0) begin
            $error("Result transaction with nothing expected: status %0b byte 0x%0h",
                   got.status, got.payload_byte);
            fail_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("status", SUM_W'(want.status), SUM_W'(got.status));
         compare_field("payload_byte", SUM_W'(want.payload_byte),
                       SUM_W'(got.payload_byte));
         compare_field("byte_index", SUM_W'(want.byte_index), SUM_W'(got.byte_index));
         compare_field("last_of_run", SUM_W'(want.last_of_run), SUM_W'(got.last_of_run));
         compare_field("sum_received", want.sum_received, got.sum_received);
         compare_field("sum_computed", want.sum_computed, got.sum_computed);
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   localparam int ITEM_TARGET  = 330;
   localparam int IDLE_PERCENT = 18;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 60;
   localparam int CYCLE_LIMIT  = 200000;

   typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_SYNC_MIX} fill_style_type;

   logic                clock;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte  = '0;
   logic                rsp_valid;
   logic                rsp_stall    = 1'b0;
   logic                rsp_status;
   logic [BYTE_W-1:0]   rsp_payload_byte;
   logic [IDX_W-1:0]    rsp_byte_index;
   logic                rsp_last_of_run;
   logic [SUM_W-1:0]    rsp_sum_received;
   logic [SUM_W-1:0]    rsp_sum_computed;

   frame_scoreboard     sb = new();
   bit                  idle_enable   = 1'b1;
   int                  items_sent    = 0;
   int                  results_taken = 0;
   int                  hold_left     = 0;
   bit                  hold_done     = 1'b0;
   int                  cycle_count   = 0;
   frame_result_type    got_result;

   sync_word_frame_checker_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_sum_received (rsp_sum_received),
      .rsp_sum_computed (rsp_sum_computed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one byte, with an optional random gap, and wait until it is taken.
   task automatic send_rx_byte(input logic [BYTE_W-1:0] rx);
      if (idle_enable) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      sb.note_rx_byte(rx);
      items_sent++;
   endtask

   // Build a full frame with a correct or a corrupted checksum and send it.
   task automatic send_frame(input fill_style_type style, input bit corrupt);
      logic [BYTE_W-1:0] fb [FRAME_LEN];
      logic [SUM_W-1:0]  word;
      int                i;
      fb[0] = SYNC_FIRST;
      fb[1] = SYNC_SECOND;
      word  = SUM_W'(fb[0]) + SUM_W'(fb[1]);
      for (i = 2; i < FRAME_LEN - 2; i++) begin
         case (style)
            FILL_ZERO:     fb[i] = '0;
            FILL_ONES:     fb[i] = '1;
            FILL_SYNC_MIX: fb[i] = (i % 4 == 0) ? 8'h00 : (i % 4 == 1) ? 8'hFF :
                                   (i % 4 == 2) ? SYNC_FIRST : SYNC_SECOND;
            default:       fb[i] = BYTE_W'($urandom_range(0, 255));
         endcase
         word = word + SUM_W'(fb[i]);
      end
      if (corrupt) begin
         word = word ^ SUM_W'($urandom_range(1, 65535));
      end
      fb[FRAME_LEN-2] = word[7:0];
      fb[FRAME_LEN-1] = word[15:8];
      for (i = 0; i < FRAME_LEN; i++) begin
         send_rx_byte(fb[i]);
      end
   endtask

   // Stop offering bytes until every expected result has arrived.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // Result side: check accepted transactions, then pick the next stall value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         got_result.status       = rsp_status;
         got_result.payload_byte = rsp_payload_byte;
         got_result.byte_index   = rsp_byte_index;
         got_result.last_of_run  = rsp_last_of_run;
         got_result.sum_received = rsp_sum_received;
         got_result.sum_computed = rsp_sum_computed;
         sb.check_result(got_result);
         results_taken++;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!hold_done && results_taken >= HOLD_AT) begin
         // One long hold-off so the block backs up and stalls its input.
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_enable && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   // Watchdog on the total run length.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int                pick;
      int                style_pick;
      logic [BYTE_W-1:0] second;
      fill_style_type    style;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: noise, broken sync pairs, then a good frame with extreme payload.
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
      send_rx_byte(SYNC_FIRST);
      send_rx_byte(8'h00);
      // The second 0xAA breaks the pair and is not taken as a new first sync byte.
      send_rx_byte(SYNC_FIRST);
      send_rx_byte(SYNC_FIRST);
      send_rx_byte(SYNC_SECOND);
      send_frame(FILL_SYNC_MIX, 1'b0);

      // Random: mostly frames, some noise and broken sync pairs.
      while (items_sent < ITEM_TARGET) begin
         if (items_sent >= 150 && items_sent < 240) begin
            idle_enable = 1'b0;
         end else if (items_sent >= 240 && !idle_enable) begin
            idle_enable = 1'b1;
            wait_for_drain();
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_rx_byte(BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 16) begin
            second = BYTE_W'($urandom_range(0, 255));
            if (second == SYNC_SECOND) begin
               second = second ^ 8'h01;
            end
            send_rx_byte(SYNC_FIRST);
            send_rx_byte(second);
         end else begin
            style_pick = $urandom_range(0, 9);
            style = (style_pick == 0) ? FILL_ZERO :
                    (style_pick == 1) ? FILL_ONES : FILL_RANDOM;
            send_frame(style, $urandom_range(0, 3) == 0);
         end
      end

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $error("%0d expected result transactions never arrived", sb.outstanding());
         sb.fail_count++;
      end
      if (sb.fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
